// ===== rtl/ucd_pkg.sv =====
`default_nettype none
package ucd_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CFG_WIDTH-1:0] RESET_WAIT_DEFAULT = 16'd500;
   localparam logic [CFG_WIDTH-1:0] BOOT_WAIT_DEFAULT  = 16'd10000;

   typedef enum logic [2:0] {
      ST_INIT      = 3'd0,
      ST_RESUME    = 3'd1,
      ST_UNPLUGGED = 3'd2,
      ST_WAIT      = 3'd3,
      ST_HOST      = 3'd4,
      ST_ACA       = 3'd5,
      ST_WALL      = 3'd6
   } state_type;

   typedef enum logic [2:0] {
      FN_VBUS_HIGH = 3'd0,
      FN_VBUS_LOW  = 3'd1,
      FN_USB_RESET = 3'd2,
      FN_TICK      = 3'd3,
      FN_SUSPEND   = 3'd4,
      FN_RESUME    = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      CHG_BATTERY = 2'd0,
      CHG_USB     = 2'd1,
      CHG_MAINS   = 2'd2
   } charger_kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RESET_WAIT = 1'd0,
      CSR_BOOT_WAIT  = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [2:0] mode_state;
      logic [1:0] charger_type;
      logic       charger_update;
      logic       otg_host;
      logic       otg_update;
      logic       event_ignored;
   } rsp_payload_type;

   // Clamp a register value to the countdown range.
   function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [CFG_WIDTH-1:0] ticks);
      logic [32:0] value;
      logic [32:0] limit;
      value = 33'(ticks);
      limit = (33'd1 << TIMER_WIDTH) - 33'd1;
      if (value > limit) begin
         value = limit;
      end
      return value[TIMER_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ucd_channels.sv =====
`default_nettype none
interface ucd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic       aca_detected;

   modport source (output valid, output func, output aca_detected, input ready);
   modport sink   (input valid, input func, input aca_detected, output ready);
endinterface

interface ucd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode_state;
   logic [1:0] charger_type;
   logic       charger_update;
   logic       otg_host;
   logic       otg_update;
   logic       event_ignored;

   modport source (output valid, output mode_state, output charger_type,
                   output charger_update, output otg_host, output otg_update,
                   output event_ignored, input ready);
   modport sink   (input valid, input mode_state, input charger_type,
                   input charger_update, input otg_host, input otg_update,
                   input event_ignored, output ready);
endinterface
`default_nettype wire

// ===== rtl/usb_charger_detect_fsm_top.sv =====
// USB charger detection and OTG mode controller.
// Events arrive on the req_ch channel (valid/ready): func selects vbus high,
// vbus low, usb reset, 1 ms tick, suspend or resume, and aca_detected is
// sampled with every event. Each transfer on req_ch produces exactly one
// transfer on rsp_ch carrying the state after the event, the charger type,
// the OTG mode and the update and ignored flags.
// The result is registered (in the skid register while the receiver stalls).
// One event is taken per cycle while the receiver takes results; the state
// update is one combinational pass from the state registers to the result.
// The csr_ port writes the two wait-window lengths in ticks; write them only
// while no result is outstanding.
// Reset (synchronous, active high) returns the machine to init, stops the
// countdown, selects battery only and device mode, empties the result
// path and restores the default window lengths.
// When the receiver stalls, the result register holds and one further
// event is taken into a skid register; req_ch.ready then drops until the
// receiver takes a result.
`default_nettype none
module usb_charger_detect_fsm_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ucd_req_if.sink                                 req_ch,
   ucd_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_wr_en,
   input  wire logic [ucd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ucd_pkg::CFG_WIDTH-1:0]       csr_wr_data
);
   import ucd_pkg::*;

   logic [CFG_WIDTH-1:0]   reset_wait_ff, reset_wait_in;
   logic [CFG_WIDTH-1:0]   boot_wait_ff, boot_wait_in;
   state_type              state_ff, state_in;
   logic [TIMER_WIDTH-1:0] count_ff, count_in;
   logic                   running_ff, running_in;
   charger_kind_type       charger_ff, charger_in;
   logic                   otg_host_ff, otg_host_in;

   rsp_payload_type        result;
   rsp_payload_type        out_ff, out_in;
   rsp_payload_type        skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   logic                   accept;
   logic                   out_take;
   logic                   chg_upd;
   logic                   otg_upd;
   logic                   ignored;
   logic                   timeout;

   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && !skid_valid_ff;
   assign out_take     = out_valid_ff && rsp_ch.ready;

   // Configuration registers.
   always_comb begin
      reset_wait_in = reset_wait_ff;
      boot_wait_in  = boot_wait_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_RESET_WAIT: reset_wait_in = csr_wr_data;
            CSR_BOOT_WAIT:  boot_wait_in  = csr_wr_data;
            default: ;
         endcase
      end
   end

   // Event processing for the accepted item.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      running_in  = running_ff;
      charger_in  = charger_ff;
      otg_host_in = otg_host_ff;
      chg_upd     = 1'b0;
      otg_upd     = 1'b0;
      ignored     = 1'b0;
      timeout     = 1'b0;

      case (func_type'(req_ch.func))
         FN_VBUS_HIGH: begin
            if (state_ff == ST_INIT || state_ff == ST_RESUME || state_ff == ST_UNPLUGGED) begin
               count_in   = (state_ff == ST_INIT) ? timer_load(boot_wait_ff)
                                                  : timer_load(reset_wait_ff);
               running_in = 1'b1;
               state_in   = ST_WAIT;
            end else begin
               ignored = 1'b1;
            end
         end
         FN_VBUS_LOW: begin
            if (state_ff == ST_UNPLUGGED) begin
               ignored = 1'b1;
            end else begin
               running_in = 1'b0;
               if (state_ff == ST_ACA) begin
                  otg_host_in = 1'b0;
                  otg_upd     = 1'b1;
               end
               state_in   = ST_UNPLUGGED;
               charger_in = CHG_BATTERY;
               chg_upd    = 1'b1;
            end
         end
         FN_USB_RESET: begin
            // Only the first reset inside a running window counts.
            if (state_ff == ST_WAIT && running_ff) begin
               running_in = 1'b0;
               state_in   = ST_HOST;
               charger_in = CHG_USB;
               chg_upd    = 1'b1;
            end
         end
         FN_TICK: begin
            if (running_ff) begin
               if (count_ff <= TIMER_WIDTH'(1)) begin
                  count_in   = '0;
                  running_in = 1'b0;
                  timeout    = 1'b1;
               end else begin
                  count_in = count_ff - TIMER_WIDTH'(1);
               end
            end
         end
         FN_SUSPEND: begin
            running_in = 1'b0;
         end
         FN_RESUME: begin
            state_in = ST_RESUME;
         end
         default: begin
            ignored = 1'b1;
         end
      endcase

      // An expired window only matters while still waiting for a reset.
      if (timeout) begin
         if (state_ff != ST_WAIT) begin
            ignored = 1'b1;
         end else begin
            if (req_ch.aca_detected) begin
               state_in    = ST_ACA;
               otg_host_in = 1'b1;
               otg_upd     = 1'b1;
            end else begin
               state_in = ST_WALL;
            end
            charger_in = CHG_MAINS;
            chg_upd    = 1'b1;
         end
      end

      result.mode_state     = state_in;
      result.charger_type   = charger_in;
      result.charger_update = chg_upd;
      result.otg_host       = otg_host_in;
      result.otg_update     = otg_upd;
      result.event_ignored  = ignored;
   end

   // Result register with one skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_wait_ff <= RESET_WAIT_DEFAULT;
         boot_wait_ff  <= BOOT_WAIT_DEFAULT;
         state_ff      <= ST_INIT;
         count_ff      <= '0;
         running_ff    <= 1'b0;
         charger_ff    <= CHG_BATTERY;
         otg_host_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         reset_wait_ff <= reset_wait_in;
         boot_wait_ff  <= boot_wait_in;
         if (accept) begin
            state_ff    <= state_in;
            count_ff    <= count_in;
            running_ff  <= running_in;
            charger_ff  <= charger_in;
            otg_host_ff <= otg_host_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.mode_state     = out_ff.mode_state;
   assign rsp_ch.charger_type   = out_ff.charger_type;
   assign rsp_ch.charger_update = out_ff.charger_update;
   assign rsp_ch.otg_host       = out_ff.otg_host;
   assign rsp_ch.otg_update     = out_ff.otg_update;
   assign rsp_ch.event_ignored  = out_ff.event_ignored;

endmodule
`default_nettype wire

// ===== rtl/ucd_checker.sv =====
`default_nettype none
module ucd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] mode_state,
   input wire logic [1:0] charger_type,
   input wire logic       charger_update,
   input wire logic       otg_host,
   input wire logic       otg_update
);
   import ucd_pkg::*;

   // No result may appear in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds its value.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mode_state)
         && $stable(charger_type) && $stable(otg_host))
      else $error("stalled result changed");

   // A charger update always matches the state it leads to.
   a_charger_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && charger_update |->
         (mode_state == ST_UNPLUGGED && charger_type == CHG_BATTERY)
         || (mode_state == ST_HOST && charger_type == CHG_USB)
         || (mode_state == ST_ACA && charger_type == CHG_MAINS)
         || (mode_state == ST_WALL && charger_type == CHG_MAINS))
      else $error("charger update inconsistent with state");

   // An OTG switch goes to host on entering ACA and to device on unplug.
   a_otg_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && otg_update |->
         (mode_state == ST_ACA && otg_host) || (mode_state == ST_UNPLUGGED && !otg_host))
      else $error("OTG update inconsistent with state");

endmodule

bind usb_charger_detect_fsm_top ucd_checker u_ucd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .mode_state     (rsp_ch.mode_state),
   .charger_type   (rsp_ch.charger_type),
   .charger_update (rsp_ch.charger_update),
   .otg_host       (rsp_ch.otg_host),
   .otg_update     (rsp_ch.otg_update)
);
`default_nettype wire
